>>> rtl/core/gfls_pkg.sv
// Shared constants, types and field arithmetic for the GF(2^8) linear solver.
package gfls_pkg;

  localparam int MaxUnknowns = 16;
  localparam int RowW        = $clog2(MaxUnknowns);
  localparam int CntW        = RowW + 1;
  localparam int ColW        = CntW;
  localparam int AddrW       = RowW + ColW;
  localparam int MemDepth    = 1 << AddrW;

  // Column slots beyond the coefficients: right-hand side and solution byte
  localparam logic [ColW-1:0] ColRhs = ColW'(MaxUnknowns);
  localparam logic [ColW-1:0] ColSol = ColW'(MaxUnknowns + 1);

  localparam logic [8:0] PolyReset = 9'h11B;
  localparam logic [CntW-1:0] NumReset = CntW'(MaxUnknowns);

  typedef enum logic [0:0] {
    OpWrite = 1'b0,
    OpSolve = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    RegPoly = 1'b0,
    RegNum  = 1'b1
  } reg_index_e;

  typedef enum logic [4:0] {
    StIdle, StSrRd, StSrChk, StSwap, StInv, StScRd, StScWr,
    StElFRd, StElF, StElPRd, StElP, StElR, StNextJ,
    StBsRd, StBsChk, StBsAcc0, StBsARd, StBsA, StBsS, StBsWr,
    StOutRd, StOutLd, StSing
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic            load;
    logic [RowW-1:0] idx;
    logic [7:0]      val;
    logic            status;
    logic            last;
  } result_t;

  // Carry-less product reduced by x^8 + low terms of the polynomial
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b, logic [8:0] poly);
    logic [14:0] p;
    logic [14:0] pf;
    p  = '0;
    pf = {6'b0, 1'b1, poly[7:0]};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ (15'(a) << i);
    end
    for (int i = 14; i >= 8; i--) begin
      if (p[i]) p = p ^ (pf << (i - 8));
    end
    return p[7:0];
  endfunction

endpackage

>>> rtl/core/gf256_linear_system_solver.sv
// Top level of the GF(2^8) linear system solver: store, sequencer and output register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  cfg     | in        | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//  in      | in        | in_valid_i / in_ready_o   | opcode, row_index, col_index, is_rhs, value
//  out     | out       | out_valid_o / out_ready_i | unknown_index, solution_value, status, last
//
// A write item goes straight into the store. A solve runs on the single read port of the
// matrix store: elimination with an inverse search for each pivot, then back-substitution
// and the readout of the solution bytes.
// Reset clears control state and loads the reset configuration; the store is not cleared.
// A stalled output holds the sequencer only when the next result is ready to load.
module gf256_linear_system_solver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [8:0]                cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [gfls_pkg::RowW-1:0] row_index_i,
  input  logic [gfls_pkg::RowW-1:0] col_index_i,
  input  logic                      is_rhs_i,
  input  logic [7:0]                value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [gfls_pkg::RowW-1:0] unknown_index_o,
  output logic [7:0]                solution_value_o,
  output logic                      status_o,
  output logic                      last_o
);

  gfls_pkg::mem_req_t mem_req;
  gfls_pkg::result_t  res;
  logic [7:0]         rdata;
  logic               slot_free;

  assign slot_free = !out_valid_o || out_ready_i;

  gfls_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  gfls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .is_rhs_i    (is_rhs_i),
    .value_i     (value_i),
    .slot_free_i (slot_free),
    .res_o       (res),
    .mem_o       (mem_req),
    .rdata_i     (rdata)
  );

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res.load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (res.load) begin
      unknown_index_o  <= res.idx;
      solution_value_o <= res.val;
      status_o         <= res.status;
      last_o           <= res.last;
    end
  end

endmodule

>>> rtl/core/gfls_mem.sv
// Matrix, right-hand side and solution store: one write port, one registered read port.
module gfls_mem (
  input  logic                      clk_i,
  input  gfls_pkg::mem_req_t        req_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem_q [gfls_pkg::MemDepth];

  // Write the requested entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

>>> rtl/core/gfls_ctrl.sv
// Elimination sequencer: walks the matrix store, holds row order and configuration.
module gfls_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [8:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [gfls_pkg::RowW-1:0]     row_index_i,
  input  logic [gfls_pkg::RowW-1:0]     col_index_i,
  input  logic                          is_rhs_i,
  input  logic [7:0]                    value_i,
  input  logic                          slot_free_i,
  output gfls_pkg::result_t             res_o,
  output gfls_pkg::mem_req_t            mem_o,
  input  logic [7:0]                    rdata_i
);

  localparam int RW = gfls_pkg::RowW;
  localparam int CW = gfls_pkg::CntW;

  gfls_pkg::state_e state_q, state_d;

  logic [8:0]    poly_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] j_q, k_q, l_q, c_q, i_q;
  logic [RW-1:0] ro_q [gfls_pkg::MaxUnknowns];
  logic [RW-1:0] rk_q, p_q, r_q;
  logic [7:0]    piv_q, y_q, iv_q, f_q, pc_q, a_q, acc_q;
  logic [7:0]    mul_a, mul_b, mul_y;
  logic [gfls_pkg::ColW-1:0] col_c;
  logic          in_xfer;

  assign in_ready_o = (state_q == gfls_pkg::StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign col_c      = (c_q == n_q) ? gfls_pkg::ColRhs : c_q;
  assign mul_y      = gfls_pkg::gf_mul(mul_a, mul_b, poly_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= gfls_pkg::PolyReset;
      n_q    <= gfls_pkg::NumReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gfls_pkg::RegPoly: poly_q <= cfg_wdata_i;
        gfls_pkg::RegNum: begin
          if (cfg_wdata_i[CW-1:0] == '0) n_q <= CW'(1);
          else if (cfg_wdata_i[CW-1:0] > gfls_pkg::NumReset) n_q <= gfls_pkg::NumReset;
          else n_q <= cfg_wdata_i[CW-1:0];
        end
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= gfls_pkg::StIdle;
    else         state_q <= state_d;
  end

  // Next state, memory requests, multiplier operands and result strobe
  always_comb begin
    state_d     = state_q;
    mem_o       = '0;
    mul_a       = '0;
    mul_b       = '0;
    res_o       = '0;
    case (state_q)
      gfls_pkg::StIdle: begin
        if (in_xfer) begin
          if (opcode_i == gfls_pkg::OpSolve) begin
            state_d = gfls_pkg::StSrRd;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.waddr = {row_index_i, is_rhs_i ? gfls_pkg::ColRhs : {1'b0, col_index_i}};
            mem_o.wdata = value_i;
          end
        end
      end
      gfls_pkg::StSrRd: begin
        mem_o.raddr = {ro_q[k_q[RW-1:0]], j_q};
        state_d     = gfls_pkg::StSrChk;
      end
      gfls_pkg::StSrChk: begin
        if (rdata_i != '0) state_d = gfls_pkg::StSwap;
        else if (k_q + CW'(1) == n_q) state_d = gfls_pkg::StSing;
        else state_d = gfls_pkg::StSrRd;
      end
      gfls_pkg::StSwap: state_d = gfls_pkg::StInv;
      gfls_pkg::StInv: begin
        mul_a = piv_q;
        mul_b = y_q;
        if (mul_y == 8'd1 || y_q == 8'hFF) state_d = gfls_pkg::StScRd;
      end
      gfls_pkg::StScRd: begin
        mem_o.raddr = {p_q, col_c};
        state_d     = gfls_pkg::StScWr;
      end
      gfls_pkg::StScWr: begin
        mul_a       = iv_q;
        mul_b       = rdata_i;
        mem_o.we    = 1'b1;
        mem_o.waddr = {p_q, col_c};
        mem_o.wdata = mul_y;
        if (c_q != n_q) state_d = gfls_pkg::StScRd;
        else if (j_q + CW'(1) == n_q) state_d = gfls_pkg::StNextJ;
        else state_d = gfls_pkg::StElFRd;
      end
      gfls_pkg::StElFRd: begin
        mem_o.raddr = {ro_q[l_q[RW-1:0]], j_q};
        state_d     = gfls_pkg::StElF;
      end
      gfls_pkg::StElF: state_d = gfls_pkg::StElPRd;
      gfls_pkg::StElPRd: begin
        mem_o.raddr = {p_q, col_c};
        state_d     = gfls_pkg::StElP;
      end
      gfls_pkg::StElP: begin
        mem_o.raddr = {r_q, col_c};
        state_d     = gfls_pkg::StElR;
      end
      gfls_pkg::StElR: begin
        mul_a       = pc_q;
        mul_b       = f_q;
        mem_o.we    = 1'b1;
        mem_o.waddr = {r_q, col_c};
        mem_o.wdata = rdata_i ^ mul_y;
        if (c_q != n_q) state_d = gfls_pkg::StElPRd;
        else if (l_q + CW'(1) == n_q) state_d = gfls_pkg::StNextJ;
        else state_d = gfls_pkg::StElFRd;
      end
      gfls_pkg::StNextJ: begin
        if (j_q + CW'(1) == n_q) state_d = gfls_pkg::StBsRd;
        else state_d = gfls_pkg::StSrRd;
      end
      gfls_pkg::StBsRd: begin
        mem_o.raddr = {ro_q[j_q[RW-1:0]], j_q};
        state_d     = gfls_pkg::StBsChk;
      end
      gfls_pkg::StBsChk: begin
        mem_o.raddr = {p_q, gfls_pkg::ColRhs};
        if (rdata_i == '0) state_d = gfls_pkg::StSing;
        else state_d = gfls_pkg::StBsAcc0;
      end
      gfls_pkg::StBsAcc0: begin
        if (j_q + CW'(1) == n_q) state_d = gfls_pkg::StBsWr;
        else state_d = gfls_pkg::StBsARd;
      end
      gfls_pkg::StBsARd: begin
        mem_o.raddr = {p_q, i_q};
        state_d     = gfls_pkg::StBsA;
      end
      gfls_pkg::StBsA: begin
        mem_o.raddr = {i_q[RW-1:0], gfls_pkg::ColSol};
        state_d     = gfls_pkg::StBsS;
      end
      gfls_pkg::StBsS: begin
        mul_a = a_q;
        mul_b = rdata_i;
        if (i_q + CW'(1) == n_q) state_d = gfls_pkg::StBsWr;
        else state_d = gfls_pkg::StBsARd;
      end
      gfls_pkg::StBsWr: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = {j_q[RW-1:0], gfls_pkg::ColSol};
        mem_o.wdata = acc_q;
        if (j_q == '0) state_d = gfls_pkg::StOutRd;
        else state_d = gfls_pkg::StBsRd;
      end
      gfls_pkg::StOutRd: begin
        mem_o.raddr = {i_q[RW-1:0], gfls_pkg::ColSol};
        state_d     = gfls_pkg::StOutLd;
      end
      gfls_pkg::StOutLd: begin
        // hold the read address so the data stays valid while the slot is busy
        mem_o.raddr = {i_q[RW-1:0], gfls_pkg::ColSol};
        if (slot_free_i) begin
          res_o.load   = 1'b1;
          res_o.idx    = i_q[RW-1:0];
          res_o.val    = rdata_i;
          res_o.status = 1'b0;
          res_o.last   = (i_q + CW'(1) == n_q);
          state_d      = res_o.last ? gfls_pkg::StIdle : gfls_pkg::StOutRd;
        end
      end
      gfls_pkg::StSing: begin
        if (slot_free_i) begin
          res_o.load   = 1'b1;
          res_o.idx    = j_q[RW-1:0];
          res_o.val    = '0;
          res_o.status = 1'b1;
          res_o.last   = 1'b1;
          state_d      = gfls_pkg::StIdle;
        end
      end
      default: state_d = gfls_pkg::StIdle;
    endcase
  end

  // Advance counters and latch operands
  always_ff @(posedge clk_i) begin
    case (state_q)
      gfls_pkg::StIdle: begin
        if (in_xfer && opcode_i == gfls_pkg::OpSolve) begin
          for (int m = 0; m < gfls_pkg::MaxUnknowns; m++) ro_q[m] <= RW'(m);
          j_q <= '0;
          k_q <= '0;
        end
      end
      gfls_pkg::StSrRd: rk_q <= ro_q[k_q[RW-1:0]];
      gfls_pkg::StSrChk: begin
        piv_q <= rdata_i;
        if (rdata_i == '0) k_q <= k_q + CW'(1);
      end
      gfls_pkg::StSwap: begin
        if (k_q != j_q) ro_q[k_q[RW-1:0]] <= ro_q[j_q[RW-1:0]];
        ro_q[j_q[RW-1:0]] <= rk_q;
        p_q <= rk_q;
        y_q <= 8'd1;
      end
      gfls_pkg::StInv: begin
        c_q <= '0;
        if (mul_y == 8'd1) iv_q <= y_q;
        else if (y_q == 8'hFF) iv_q <= '0;
        else y_q <= y_q + 8'd1;
      end
      gfls_pkg::StScWr: begin
        c_q <= c_q + CW'(1);
        l_q <= j_q + CW'(1);
      end
      gfls_pkg::StElFRd: r_q <= ro_q[l_q[RW-1:0]];
      gfls_pkg::StElF: begin
        f_q <= rdata_i;
        c_q <= j_q;
      end
      gfls_pkg::StElP: pc_q <= rdata_i;
      gfls_pkg::StElR: begin
        if (c_q != n_q) c_q <= c_q + CW'(1);
        else l_q <= l_q + CW'(1);
      end
      gfls_pkg::StNextJ: begin
        if (j_q + CW'(1) == n_q) begin
          j_q <= n_q - CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
          k_q <= j_q + CW'(1);
        end
      end
      gfls_pkg::StBsRd: p_q <= ro_q[j_q[RW-1:0]];
      gfls_pkg::StBsAcc0: begin
        acc_q <= rdata_i;
        i_q   <= j_q + CW'(1);
      end
      gfls_pkg::StBsA: a_q <= rdata_i;
      gfls_pkg::StBsS: begin
        acc_q <= acc_q ^ mul_y;
        i_q   <= i_q + CW'(1);
      end
      gfls_pkg::StBsWr: begin
        i_q <= '0;
        if (j_q != '0) j_q <= j_q - CW'(1);
      end
      gfls_pkg::StOutLd: begin
        if (slot_free_i) i_q <= i_q + CW'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> bench/testbench.sv
// Testbench for the GF(2^8) linear system solver: directed table, random systems, predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int N_MAX     = 16;
  localparam int LIMIT     = 1000000;
  localparam int SETTLE    = 16;
  localparam int RND_ITEMS = 45;

  typedef enum logic [0:0] {
    KindItem = 1'b0,
    KindCfg  = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    gfls_pkg::opcode_e    op;
    logic [3:0]           row;
    logic [3:0]           col;
    logic                 rhs;
    logic [7:0]           val;
    gfls_pkg::reg_index_e cfg_idx;
    logic [8:0]           cfg_val;
    logic                 typed;
    logic [3:0]           e_idx;
    logic [7:0]           e_val;
    logic                 e_st;
  } dir_row_t;

  typedef struct {
    logic [3:0] idx;
    logic [7:0] val;
    logic       st;
    logic       last;
  } sol_t;

  logic       clk_i, rst_ni;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [8:0] cfg_wdata_i;
  logic       in_valid_i, in_ready_o;
  logic       opcode_i;
  logic [3:0] row_index_i, col_index_i;
  logic       is_rhs_i;
  logic [7:0] value_i;
  logic       out_valid_o, out_ready_i;
  logic [3:0] unknown_index_o;
  logic [7:0] solution_value_o;
  logic       status_o, last_o;

  gf256_linear_system_solver u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .opcode_i, .row_index_i, .col_index_i, .is_rhs_i, .value_i,
    .out_valid_o, .out_ready_i, .unknown_index_o, .solution_value_o, .status_o, .last_o
  );

  // Predictor state
  logic [7:0] mat [N_MAX][N_MAX];
  logic [7:0] rhs_v [N_MAX];
  logic [7:0] sol_v [N_MAX];
  logic [3:0] order [N_MAX];
  logic [8:0] poly_q;
  logic [4:0] num_q;
  sol_t       solution_q [$];

  dir_row_t   dir_tab [$];
  int         errors, cycles, n_results, n_solves, n_singular, n_items;
  bit         quiet, press_req;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, solution_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Field product: shift a up, folding x^8 back in through the polynomial
  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc, sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= sh;
      sh = sh[7] ? ((sh << 1) ^ poly_q[7:0]) : (sh << 1);
    end
    return acc;
  endfunction

  function automatic logic [7:0] finv(input logic [7:0] x);
    if (x == 8'd0) return 8'd0;
    for (int y = 1; y < 256; y++) begin
      if (fmul(x, 8'(y)) == 8'd1) return 8'(y);
    end
    return 8'd0;
  endfunction

  function automatic int active_n();
    if (num_q == 5'd0) return 1;
    if (num_q > 5'(N_MAX)) return N_MAX;
    return int'(num_q);
  endfunction

  function automatic void push_singular(input int col);
    solution_q.push_back('{idx: 4'(col), val: 8'd0, st: 1'b1, last: 1'b1});
  endfunction

  // Gaussian elimination in place; push the expected solution bytes
  function automatic void solve_predict();
    int n, k, p, r;
    logic [3:0] t;
    logic [7:0] iv, f, acc;
    n = active_n();
    for (int i = 0; i < n; i++) order[i] = 4'(i);
    for (int j = 0; j < n; j++) begin
      for (k = j; k < n; k++) if (mat[order[k]][j] != 8'd0) break;
      if (k >= n) begin
        push_singular(j);
        return;
      end
      t = order[j]; order[j] = order[k]; order[k] = t;
      p  = order[j];
      iv = finv(mat[p][j]);
      for (int c = 0; c < n; c++) mat[p][c] = fmul(iv, mat[p][c]);
      rhs_v[p] = fmul(iv, rhs_v[p]);
      for (int l = j + 1; l < n; l++) begin
        r = order[l];
        f = mat[r][j];
        for (int c = j; c < n; c++) mat[r][c] ^= fmul(mat[p][c], f);
        rhs_v[r] ^= fmul(rhs_v[p], f);
      end
    end
    for (int j = n - 1; j >= 0; j--) begin
      p = order[j];
      if (mat[p][j] == 8'd0) begin
        push_singular(j);
        return;
      end
      acc = rhs_v[p];
      for (int i = j + 1; i < n; i++) acc ^= fmul(mat[p][i], sol_v[i]);
      sol_v[j] = acc;
    end
    for (int i = 0; i < n; i++)
      solution_q.push_back('{idx: 4'(i), val: sol_v[i], st: 1'b0, last: (i == n - 1)});
  endfunction

  function automatic void apply_item(input gfls_pkg::opcode_e op, input logic [3:0] row,
                                     input logic [3:0] col, input logic rhs,
                                     input logic [7:0] val);
    if (op == gfls_pkg::OpSolve) begin
      n_solves++;
      solve_predict();
    end else if (rhs) begin
      rhs_v[row] = val;
    end else begin
      mat[row][col] = val;
    end
  endfunction

  // Offer one item, hold it until the transfer, then update the predictor
  task automatic send_item(input gfls_pkg::opcode_e op, input logic [3:0] row,
                           input logic [3:0] col, input logic rhs, input logic [7:0] val);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    row_index_i <= row;
    col_index_i <= col;
    is_rhs_i    <= rhs;
    value_i     <= val;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    apply_item(op, row, col, rhs, val);
  endtask

  // Write a register once the block has drained and settled
  task automatic cfg_write(input gfls_pkg::reg_index_e idx, input logic [8:0] val);
    in_valid_i <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gfls_pkg::RegPoly) poly_q = val;
    else                          num_q  = val[4:0];
  endtask

  task automatic add_item(input gfls_pkg::opcode_e op, input logic [3:0] row,
                          input logic [3:0] col, input logic rhs, input logic [7:0] val);
    dir_tab.push_back('{KindItem, op, row, col, rhs, val, gfls_pkg::RegPoly, 9'd0,
                        1'b0, 4'd0, 8'd0, 1'b0});
  endtask

  task automatic add_typed(input logic [3:0] e_idx, input logic [7:0] e_val, input logic e_st);
    dir_tab.push_back('{KindItem, gfls_pkg::OpSolve, 4'd0, 4'd0, 1'b0, 8'd0,
                        gfls_pkg::RegPoly, 9'd0, 1'b1, e_idx, e_val, e_st});
  endtask

  task automatic add_cfg(input gfls_pkg::reg_index_e idx, input logic [8:0] val);
    dir_tab.push_back('{KindCfg, gfls_pkg::OpWrite, 4'd0, 4'd0, 1'b0, 8'd0, idx, val,
                        1'b0, 4'd0, 8'd0, 1'b0});
  endtask

  function automatic logic [7:0] rnd_val();
    return ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
  endfunction

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int hold, burst;
    hold  = 0;
    burst = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (solution_q.size() == 0) begin
          report($sformatf("unexpected result idx %0d", unknown_index_o));
        end else begin
          sol_t e;
          e = solution_q.pop_front();
          if (status_o == 1'b1) n_singular++;
          if (unknown_index_o !== e.idx)
            report($sformatf("unknown_index %0d, want %0d", unknown_index_o, e.idx));
          if (solution_value_o !== e.val)
            report($sformatf("solution_value %0h, want %0h (idx %0d)",
                             solution_value_o, e.val, e.idx));
          if (status_o !== e.st)
            report($sformatf("status %0d, want %0d", status_o, e.st));
          if (last_o !== e.last)
            report($sformatf("last %0d, want %0d", last_o, e.last));
        end
      end
      if (press_req) begin
        press_req = 1'b0;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int rnd_count, n, qs, groups;
    errors = 0; n_results = 0; n_solves = 0; n_singular = 0; n_items = 0;
    quiet = 1'b0; press_req = 1'b0;
    poly_q = gfls_pkg::PolyReset;
    num_q  = 5'(N_MAX);
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = gfls_pkg::RegPoly; cfg_wdata_i = '0;
    in_valid_i = 1'b0; opcode_i = gfls_pkg::OpWrite; row_index_i = '0; col_index_i = '0;
    is_rhs_i = 1'b0; value_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every coefficient and right-hand side entry so no solve reads stale data
    for (int r = 0; r < N_MAX; r++) begin
      for (int c = 0; c < N_MAX; c++)
        send_item(gfls_pkg::OpWrite, 4'(r), 4'(c), 1'b0, rnd_val());
      send_item(gfls_pkg::OpWrite, 4'(r), 4'($urandom_range(0, 15)), 1'b1, rnd_val());
    end

    // Directed table
    add_item(gfls_pkg::OpSolve, 4'd0, 4'd0, 1'b0, 8'd0);      // full size at reset settings
    add_cfg(gfls_pkg::RegNum, 9'd1);
    add_item(gfls_pkg::OpWrite, 4'd0, 4'd0, 1'b0, 8'd1);
    add_item(gfls_pkg::OpWrite, 4'd0, 4'd15, 1'b1, 8'hFF);    // rhs ignores col_index
    add_typed(4'd0, 8'hFF, 1'b0);
    add_item(gfls_pkg::OpWrite, 4'd0, 4'd0, 1'b0, 8'd0);
    add_typed(4'd0, 8'd0, 1'b1);                              // no pivot
    add_cfg(gfls_pkg::RegPoly, 9'h100);                       // reducible: x^8
    add_item(gfls_pkg::OpWrite, 4'd0, 4'd0, 1'b0, 8'd2);
    add_typed(4'd0, 8'd0, 1'b1);                              // pivot has no inverse
    add_cfg(gfls_pkg::RegPoly, 9'h01B);                       // bit 8 clear
    add_cfg(gfls_pkg::RegNum, 9'd0);                          // taken as one unknown
    add_item(gfls_pkg::OpWrite, 4'd0, 4'd0, 1'b0, 8'd1);
    add_item(gfls_pkg::OpWrite, 4'd0, 4'd0, 1'b1, 8'h5A);
    add_typed(4'd0, 8'h5A, 1'b0);
    add_cfg(gfls_pkg::RegPoly, 9'h1FF);
    add_cfg(gfls_pkg::RegNum, 9'h1FF);                        // saturates to full size
    add_item(gfls_pkg::OpWrite, 4'd15, 4'd15, 1'b0, 8'hFF);
    add_item(gfls_pkg::OpWrite, 4'd15, 4'd0, 1'b1, 8'h80);
    add_item(gfls_pkg::OpSolve, 4'd0, 4'd0, 1'b0, 8'd0);
    add_cfg(gfls_pkg::RegPoly, 9'h11B);
    add_cfg(gfls_pkg::RegNum, 9'd2);
    add_item(gfls_pkg::OpSolve, 4'd0, 4'd0, 1'b0, 8'd0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == KindCfg) begin
        cfg_write(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
      end else begin
        if (dir_tab[i].op == gfls_pkg::OpSolve && n_solves == 1) press_req = 1'b1;
        qs = solution_q.size();
        send_item(dir_tab[i].op, dir_tab[i].row, dir_tab[i].col, dir_tab[i].rhs,
                  dir_tab[i].val);
        // Typed rows replace what the predictor pushed
        if (dir_tab[i].typed) begin
          while (solution_q.size() > qs) void'(solution_q.pop_back());
          solution_q.push_back('{idx: dir_tab[i].e_idx, val: dir_tab[i].e_val,
                                 st: dir_tab[i].e_st, last: 1'b1});
        end
      end
    end

    // Random phases: new settings, then a few systems refreshed in part, with noise
    rnd_count = 0;
    while (rnd_count < RND_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       cfg_write(gfls_pkg::RegPoly, 9'h11B);
        1:       cfg_write(gfls_pkg::RegPoly, 9'h100);
        2:       cfg_write(gfls_pkg::RegPoly, 9'h1FF);
        3:       cfg_write(gfls_pkg::RegPoly, 9'($urandom_range(0, 255)));
        default: cfg_write(gfls_pkg::RegPoly, 9'($urandom_range(256, 511)));
      endcase
      case ($urandom_range(0, 19))
        0:       cfg_write(gfls_pkg::RegNum, 9'd0);
        1:       cfg_write(gfls_pkg::RegNum, 9'd16);
        2:       cfg_write(gfls_pkg::RegNum, 9'($urandom_range(17, 31)));
        default: cfg_write(gfls_pkg::RegNum, 9'($urandom_range(1, 5)));
      endcase
      n = active_n();
      groups = $urandom_range(2, 4);
      for (int g = 0; g < groups && rnd_count < RND_ITEMS; g++) begin
        quiet = (rnd_count > RND_ITEMS * 4 / 5);
        for (int r = 0; r < n; r++) begin
          // About two fresh coefficients per row; the rest keep earlier values
          for (int c = 0; c < n; c++) begin
            if ($urandom_range(0, n - 1) < 2) begin
              send_item(gfls_pkg::OpWrite, 4'(r), 4'(c), 1'b0, rnd_val());
              rnd_count++;
            end
          end
          send_item(gfls_pkg::OpWrite, 4'(r), 4'($urandom_range(0, 15)), 1'b1,
                    8'($urandom_range(0, 255)));
          rnd_count++;
        end
        // Zero a column now and then to force a singular system
        if ($urandom_range(0, 4) == 0) begin
          int zc;
          zc = $urandom_range(0, n - 1);
          for (int r = 0; r < n; r++) begin
            send_item(gfls_pkg::OpWrite, 4'(r), 4'(zc), 1'b0, 8'd0);
            rnd_count++;
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          send_item(gfls_pkg::OpWrite, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)), rnd_val());
          rnd_count++;
        end
        send_item(gfls_pkg::OpSolve, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        rnd_count++;
      end
    end

    // Drain
    in_valid_i <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d items, %0d solves, %0d results (%0d singular)",
             n_items, n_solves, n_results, n_singular);
    $display("settings swept: poly reset, reducible, bit 8 clear, all ones; sizes 0 to 31");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
